// ----- rtl/core/csim_pkg.sv -----
package csim_pkg;

   // element and result widths
   localparam int ELEM_W = 16;
   localparam int SIM_W  = 16;

   // accumulator widths
   localparam int DOT_W  = 44;
   localparam int SQ_W   = 43;

   // shared multiplier limb and wide accumulator widths
   localparam int LIMB_W = 32;
   localparam int PROD_W = 3 * LIMB_W;
   localparam int ACC_W  = 4 * LIMB_W;

   // special result codes
   localparam logic [SIM_W-1:0] SIM_NEG_ONE = {1'b1, {(SIM_W-1){1'b0}}};
   localparam logic [SIM_W-1:0] SIM_POS_MAX = {1'b0, {(SIM_W-1){1'b1}}};

endpackage

// ----- rtl/core/cosine_similarity_stream.sv -----
// cosine similarity of two streamed vectors, signed Q1.15
//
// req channel: one element pair per transaction (req_left_value, req_right_value),
// req_last marks the final pair. rsp channel: one transaction per vector pair,
// rsp_similarity in Q1.15 and rsp_degenerate when either vector is all zero.
// A single 32x32 multiplier is shared by every step. An element pair goes
// through three products, each multiply then accumulate, before the return
// to idle, and req_ready is low meanwhile. After the last pair the block
// forms the product of the square sums, the squared dot and then a 16-step
// bit search for the rounded quotient, with every limb product going
// through the one multiplier.
// The result sits in an output register: the next vector may start while it
// waits, and if rsp_ready stays low the block holds the following result
// until the register frees up. Synchronous reset clears the three
// accumulators and drops rsp_valid.
module cosine_similarity_stream (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [csim_pkg::ELEM_W-1:0] req_left_value,
   input  logic signed [csim_pkg::ELEM_W-1:0] req_right_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [csim_pkg::SIM_W-1:0] rsp_similarity,
   output logic                              rsp_degenerate
);
   import csim_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_EMUL, S_EACC, S_CHK, S_MUL, S_ADD, S_NEXT,
      S_ODD, S_ODDW, S_CMP, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {PH_PROD, PH_RHS, PH_TRY} phase_type;

   state_type            state_ff;
   phase_type            phase_ff;
   logic [1:0]           k_ff;
   logic [1:0]           sh_ff;
   logic [1:0]           eop_ff;
   logic [ELEM_W-1:0]    l_ff, r_ff;
   logic                 last_ff;
   logic [DOT_W-1:0]     dot_ff;
   logic [SQ_W-1:0]      sq1_ff, sq2_ff;
   logic [DOT_W-1:0]     d_ff;
   logic                 neg_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [ACC_W-1:0]     rhs_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [LIMB_W-1:0]    oddsq_ff;
   logic [SIM_W-1:0]     m_ff;
   logic [SIM_W-1:0]     bit_ff;
   logic [SIM_W-1:0]     res_sim_ff;
   logic                 res_degen_ff;
   logic                 rsp_valid_ff;
   logic [SIM_W-1:0]     rsp_sim_ff;
   logic                 rsp_degen_ff;

   logic [LIMB_W-1:0]    mul_a, mul_b;
   logic [2*LIMB_W-1:0]  mul_p;
   logic [ELEM_W-1:0]    lmag, rmag;
   logic [2*LIMB_W-1:0]  sq1_w, sq2_w, d_w;
   logic [SIM_W-1:0]     trial;
   logic                 trial_skip;
   logic [SIM_W-1:0]     odd;
   logic [ACC_W-1:0]     acc_term;
   logic [DOT_W:0]       pmag_dot, dot_term, dot_sum_in;
   logic [DOT_W-1:0]     dot_in;
   logic [SQ_W:0]        sq_add;
   logic [SQ_W-1:0]      sq_sum_in;
   logic                 last_k;

   // element magnitudes and limb views
   assign lmag  = l_ff[ELEM_W-1] ? (~l_ff + 1'b1) : l_ff;
   assign rmag  = r_ff[ELEM_W-1] ? (~r_ff + 1'b1) : r_ff;
   assign sq1_w = {{(2*LIMB_W-SQ_W){1'b0}}, sq1_ff};
   assign sq2_w = {{(2*LIMB_W-SQ_W){1'b0}}, sq2_ff};
   assign d_w   = {{(2*LIMB_W-DOT_W){1'b0}}, d_ff};

   // trial quotient for the bit search
   assign trial      = m_ff | bit_ff;
   assign trial_skip = trial[SIM_W-1] && (trial[SIM_W-2:0] != '0);
   assign odd        = {trial[SIM_W-2:0], 1'b0} - 1'b1;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EMUL: begin
            case (eop_ff)
               2'd0:    begin mul_a = LIMB_W'(lmag); mul_b = LIMB_W'(rmag); end
               2'd1:    begin mul_a = LIMB_W'(lmag); mul_b = LIMB_W'(lmag); end
               default: begin mul_a = LIMB_W'(rmag); mul_b = LIMB_W'(rmag); end
            endcase
         end
         S_MUL: begin
            case (phase_ff)
               PH_PROD: begin
                  mul_a = k_ff[1] ? sq1_w[2*LIMB_W-1:LIMB_W] : sq1_w[LIMB_W-1:0];
                  mul_b = k_ff[0] ? sq2_w[2*LIMB_W-1:LIMB_W] : sq2_w[LIMB_W-1:0];
               end
               PH_RHS: begin
                  mul_a = k_ff[1] ? d_w[2*LIMB_W-1:LIMB_W] : d_w[LIMB_W-1:0];
                  mul_b = k_ff[0] ? d_w[2*LIMB_W-1:LIMB_W] : d_w[LIMB_W-1:0];
               end
               default: begin
                  case (k_ff)
                     2'd0:    mul_a = prod_ff[LIMB_W-1:0];
                     2'd1:    mul_a = prod_ff[2*LIMB_W-1:LIMB_W];
                     default: mul_a = prod_ff[3*LIMB_W-1:2*LIMB_W];
                  endcase
                  mul_b = oddsq_ff;
               end
            endcase
         end
         S_ODD: begin
            mul_a = LIMB_W'(odd);
            mul_b = LIMB_W'(odd);
         end
         default: ;
      endcase
   end

   csim_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // limb product aligned into the wide accumulator
   always_comb begin
      case (sh_ff)
         2'd0:    acc_term = {{(2*LIMB_W){1'b0}}, mul_p};
         2'd1:    acc_term = {{LIMB_W{1'b0}}, mul_p, {LIMB_W{1'b0}}};
         default: acc_term = {mul_p, {(2*LIMB_W){1'b0}}};
      endcase
   end

   assign last_k = (phase_ff == PH_TRY) ? (k_ff == 2'd2) : (k_ff == 2'd3);

   // saturating element accumulation
   always_comb begin
      pmag_dot   = {{(DOT_W+1-LIMB_W){1'b0}}, mul_p[LIMB_W-1:0]};
      dot_term   = (l_ff[ELEM_W-1] ^ r_ff[ELEM_W-1]) ? (~pmag_dot + 1'b1) : pmag_dot;
      dot_sum_in = {dot_ff[DOT_W-1], dot_ff} + dot_term;
      if (dot_sum_in[DOT_W] != dot_sum_in[DOT_W-1])
         dot_in = dot_sum_in[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
      else
         dot_in = dot_sum_in[DOT_W-1:0];
      sq_add = {1'b0, (eop_ff == 2'd1) ? sq1_ff : sq2_ff}
               + {{(SQ_W+1-LIMB_W){1'b0}}, mul_p[LIMB_W-1:0]};
      sq_sum_in = sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PROD;
         k_ff         <= '0;
         eop_ff       <= '0;
         dot_ff       <= '0;
         sq1_ff       <= '0;
         sq2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drained result frees the output register
         if (rsp_ready && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  l_ff     <= req_left_value;
                  r_ff     <= req_right_value;
                  last_ff  <= req_last;
                  eop_ff   <= '0;
                  state_ff <= S_EMUL;
               end
            end
            S_EMUL: state_ff <= S_EACC;
            S_EACC: begin
               case (eop_ff)
                  2'd0:    dot_ff <= dot_in;
                  2'd1:    sq1_ff <= sq_sum_in;
                  default: sq2_ff <= sq_sum_in;
               endcase
               if (eop_ff == 2'd2)
                  state_ff <= last_ff ? S_CHK : S_IDLE;
               else begin
                  eop_ff   <= eop_ff + 2'd1;
                  state_ff <= S_EMUL;
               end
            end
            S_CHK: begin
               if (sq1_ff == '0 || sq2_ff == '0) begin
                  res_sim_ff   <= SIM_NEG_ONE;
                  res_degen_ff <= 1'b1;
                  dot_ff       <= '0;
                  sq1_ff       <= '0;
                  sq2_ff       <= '0;
                  state_ff     <= S_OUT;
               end else begin
                  d_ff     <= dot_ff[DOT_W-1] ? (~dot_ff + 1'b1) : dot_ff;
                  neg_ff   <= dot_ff[DOT_W-1];
                  acc_ff   <= '0;
                  k_ff     <= '0;
                  phase_ff <= PH_PROD;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               sh_ff    <= (phase_ff == PH_TRY) ? k_ff : (2'(k_ff[1]) + 2'(k_ff[0]));
               state_ff <= S_ADD;
            end
            S_ADD: begin
               acc_ff <= acc_ff + acc_term;
               if (last_k)
                  state_ff <= (phase_ff == PH_TRY) ? S_CMP : S_NEXT;
               else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            S_NEXT: begin
               acc_ff <= '0;
               k_ff   <= '0;
               if (phase_ff == PH_PROD) begin
                  prod_ff  <= acc_ff[PROD_W-1:0];
                  dot_ff   <= '0;
                  sq1_ff   <= '0;
                  sq2_ff   <= '0;
                  phase_ff <= PH_RHS;
                  state_ff <= S_MUL;
               end else begin
                  rhs_ff   <= {acc_ff[ACC_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
                  m_ff     <= '0;
                  bit_ff   <= {1'b1, {(SIM_W-1){1'b0}}};
                  state_ff <= S_ODD;
               end
            end
            S_ODD: begin
               if (trial_skip) begin
                  bit_ff   <= bit_ff >> 1;
                  state_ff <= bit_ff[0] ? S_FIN : S_ODD;
               end else
                  state_ff <= S_ODDW;
            end
            S_ODDW: begin
               oddsq_ff <= mul_p[LIMB_W-1:0];
               acc_ff   <= '0;
               k_ff     <= '0;
               phase_ff <= PH_TRY;
               state_ff <= S_MUL;
            end
            S_CMP: begin
               if (acc_ff <= rhs_ff)
                  m_ff <= trial;
               bit_ff   <= bit_ff >> 1;
               state_ff <= bit_ff[0] ? S_FIN : S_ODD;
            end
            S_FIN: begin
               if (neg_ff)
                  res_sim_ff <= ~m_ff + 1'b1;
               else
                  res_sim_ff <= m_ff[SIM_W-1] ? SIM_POS_MAX : m_ff;
               res_degen_ff <= 1'b0;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sim_ff   <= res_sim_ff;
                  rsp_degen_ff <= res_degen_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

// ----- rtl/core/csim_mul.sv -----
module csim_mul (
   input  logic                              clock,
   input  logic [csim_pkg::LIMB_W-1:0]       mul_a,
   input  logic [csim_pkg::LIMB_W-1:0]       mul_b,
   output logic [2*csim_pkg::LIMB_W-1:0]     mul_p
);
   import csim_pkg::*;

   logic [2*LIMB_W-1:0] p_ff;
   logic [2*LIMB_W-1:0] p_in;

   // one registered limb product per cycle
   assign p_in  = mul_a * mul_b;
   assign mul_p = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ----- rtl/core/csim_checker.sv -----
module csim_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [csim_pkg::SIM_W-1:0] rsp_similarity,
   input logic                              rsp_degenerate
);
   import csim_pkg::*;

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a degenerate result is always minus one
   a_degen_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_similarity == SIM_NEG_ONE))
      else $error("degenerate result not -1.0");

   // an accepted pair keeps the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted pair");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_similarity)
                                      && $stable(rsp_degenerate)))
      else $error("stalled result changed");

endmodule

bind cosine_similarity_stream csim_props u_csim_props (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_similarity (rsp_similarity),
   .rsp_degenerate (rsp_degenerate)
);

// ----- dv/csim_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, predicts each similarity and compares in order
module csim_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [csim_pkg::ELEM_W-1:0] req_left_value,
   input  logic signed [csim_pkg::ELEM_W-1:0] req_right_value,
   input  logic                               req_last,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [csim_pkg::SIM_W-1:0]  rsp_similarity,
   input  logic                               rsp_degenerate,
   output int                                 fail_count,
   output int                                 pending
);
   import csim_pkg::*;

   typedef struct packed {
      logic signed [SIM_W-1:0] similarity;
      logic                    degenerate;
   } cos_result_type;

   localparam logic signed [63:0] DOT_HI = 64'sd8796093022207;   // 2^43 - 1
   localparam logic signed [63:0] DOT_LO = -64'sd8796093022208;  // -2^43
   localparam logic [63:0]        SQ_HI  = 64'd8796093022207;

   // running accumulators of the current vector pair
   logic signed [63:0] dot_acc;
   logic [63:0]        left_sq_acc;
   logic [63:0]        right_sq_acc;
   cos_result_type     expected_sims[$];
   int                 errors;

   assign fail_count = errors;
   assign pending    = expected_sims.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // rounded dot * 2^15 / sqrt(left * right) by a bit search on the odd boundary
   function automatic cos_result_type cosine_of(input logic signed [63:0] dot,
                                                input logic [63:0] lsq,
                                                input logic [63:0] rsq);
      cos_result_type res;
      logic [127:0] prod, rhs, mag, trial, odd;
      logic [16:0]  m, t;
      logic         neg;
      res.degenerate = 1'b0;
      if (lsq == 0 || rsq == 0) begin
         res.similarity = SIM_NEG_ONE;
         res.degenerate = 1'b1;
         return res;
      end
      neg  = dot < 0;
      mag  = neg ? 128'(-dot) : 128'(dot);
      prod = 128'(lsq) * 128'(rsq);
      rhs  = (mag * mag) << 32;
      m    = '0;
      for (int b = 15; b >= 0; b--) begin
         t = m | (17'd1 << b);
         if (t > 17'd32768) continue;
         odd   = 128'(2 * t - 1);
         trial = prod * odd * odd;
         if (trial <= rhs) m = t;
      end
      if (neg) res.similarity = SIM_W'(-int'(m));
      else if (m > 17'd32767) res.similarity = SIM_POS_MAX;
      else res.similarity = SIM_W'(m);
      return res;
   endfunction

   always @(posedge clock) begin
      logic signed [63:0] l, r, nd;
      logic [63:0]        nl, nr;
      cos_result_type     want;
      if (reset) begin
         dot_acc      <= '0;
         left_sq_acc  <= '0;
         right_sq_acc <= '0;
      end else begin
         // accumulate each accepted element pair
         if (req_valid && req_ready) begin
            l  = 64'(req_left_value);
            r  = 64'(req_right_value);
            nd = dot_acc + l * r;
            if (nd > DOT_HI) nd = DOT_HI;
            if (nd < DOT_LO) nd = DOT_LO;
            nl = left_sq_acc + 64'(l * l);
            nr = right_sq_acc + 64'(r * r);
            if (nl > SQ_HI) nl = SQ_HI;
            if (nr > SQ_HI) nr = SQ_HI;
            if (req_last) begin
               expected_sims.push_back(cosine_of(nd, nl, nr));
               nd = '0;
               nl = '0;
               nr = '0;
            end
            dot_acc      <= nd;
            left_sq_acc  <= nl;
            right_sq_acc <= nr;
         end
         // compare each result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_sims.size() == 0) begin
               report_mismatch("unexpected result", rsp_similarity, 0);
            end else begin
               want = expected_sims.pop_front();
               if (rsp_similarity !== want.similarity)
                  report_mismatch("similarity", rsp_similarity, want.similarity);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, want.degenerate);
            end
         end
      end
   end
endmodule

// ----- dv/tb_cosine_similarity_stream.sv -----
`timescale 1ns / 1ps

module tb_cosine_similarity_stream;
   import csim_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_PAIRS = 1700;
   localparam int LONG_PAIRS   = 100;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_left_value = '0;
   logic signed [ELEM_W-1:0] req_right_value = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [SIM_W-1:0]  rsp_similarity;
   logic                     rsp_degenerate;
   int                       fail_count;
   int                       pending;
   int                       idle_cycles = 0;
   bit                       sender_burst = 0;

   always #5 clock = ~clock;

   cosine_similarity_stream i_dut (.*);

   csim_checker i_checker (.*);

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // send one element pair, idling first unless in a burst
   task automatic send_pair(input logic signed [ELEM_W-1:0] l,
                            input logic signed [ELEM_W-1:0] r,
                            input logic                     fin);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_left_value  <= l;
      req_right_value <= r;
      req_last        <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_element();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
         endcase
      end
      if (sel < 35) return ELEM_W'($signed($urandom_range(0, 64)) - 32);
      return ELEM_W'($urandom);
   endfunction

   // result side: random hold-off per transaction, with burst stretches
   initial begin
      int wait_cycles;
      int count;
      bit burst;
      count = 0;
      burst = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (count % 20 == 0) burst = ($urandom_range(0, 2) == 0);
         count++;
         wait_cycles = burst ? 0 : $urandom_range(0, 10);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int len, sent, mode;
      logic signed [ELEM_W-1:0] l, r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full scale, degenerate vectors, orthogonal, negative
      send_pair(16'sd32767, 16'sd32767, 1'b1);
      send_pair(-16'sd32768, -16'sd32768, 1'b1);
      send_pair(-16'sd32768, 16'sd32767, 1'b1);
      send_pair(16'sd0, 16'sd5, 1'b1);
      send_pair(16'sd7, 16'sd0, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd1, -16'sd1, 1'b1);
      send_pair(16'sd1, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b1);
      send_pair(16'sd3, 16'sd4, 1'b0);
      send_pair(-16'sd5, 16'sd12, 1'b0);
      send_pair(16'sd100, -16'sd200, 1'b1);
      send_pair(16'sd1, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd1, 1'b1);

      // hold the sender until every result is back
      req_valid <= 1'b0;
      wait (pending == 0);
      @(posedge clock);

      // long vectors at full scale
      sender_burst = 1;
      for (int i = 0; i < LONG_PAIRS; i++)
         send_pair(-16'sd32768, -16'sd32768, i == LONG_PAIRS - 1);
      for (int i = 0; i < LONG_PAIRS; i++)
         send_pair(-16'sd32768, 16'sd32767, i == LONG_PAIRS - 1);
      sender_burst = 0;

      // random vector pairs, mostly short
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         if ($urandom_range(0, 9) == 0) sender_burst = ~sender_burst;
         len  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         mode = $urandom_range(0, 19);
         for (int i = 0; i < len; i++) begin
            l = pick_element();
            r = pick_element();
            // zero vectors, parallel and antiparallel pairs
            if (mode == 0) l = '0;
            else if (mode == 1) r = '0;
            else if (mode < 5) r = l;
            else if (mode < 7) r = (l == -16'sd32768) ? 16'sd32767 : -l;
            send_pair(l, r, i == len - 1);
            sent++;
         end
      end
      req_valid <= 1'b0;
      req_last  <= 1'b0;

      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- cosine_similarity_stream.f -----
rtl/core/csim_pkg.sv
rtl/core/csim_mul.sv
rtl/core/cosine_similarity_stream.sv
rtl/core/csim_checker.sv
dv/csim_checker.sv
dv/tb_cosine_similarity_stream.sv
